// ----- design/sfrlw_pkg.sv -----
package sfrlw_pkg;

    localparam logic [7:0] FRAME_HEAD = 8'hA5;
    localparam logic [7:0] SPEED_FUNC = 8'h02;
    localparam int unsigned FRAME_LEN = 7;

    // Position of the checksum byte within a frame.
    localparam logic [2:0] SUM_POS = 3'(FRAME_LEN - 1);

    localparam logic [1:0] FS_NONE    = 2'd0;
    localparam logic [1:0] FS_GOOD    = 2'd1;
    localparam logic [1:0] FS_BAD_SUM = 2'd2;
    localparam logic [1:0] FS_FOREIGN = 2'd3;

    localparam logic [1:0] CFG_LINK_TIMEOUT   = 2'd0;
    localparam logic [1:0] CFG_REQUEST_PERIOD = 2'd1;
    localparam logic [1:0] CFG_NEGATE_A       = 2'd2;
    localparam logic [1:0] CFG_NEGATE_B       = 2'd3;

    localparam logic [15:0] LINK_TIMEOUT_RST   = 16'd100;
    localparam logic [15:0] REQUEST_PERIOD_RST = 16'd10;

    // What the frame parser reports for the byte now at its input.
    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] speed_a;
        logic [15:0] speed_b;
    } t_frame_evt;

endpackage

// ----- design/speed_frame_receiver_link_watchdog.sv -----
// Receives serial bytes and 1 ms ticks on one input stream (tuser[0] set marks a
// tick) and returns exactly one result item per input item, one item per clock
// when the output side keeps up; the result sits in a single output register.
// Bytes are gathered into 7-byte frames starting on 0xA5 with an 8-bit additive
// checksum; a good frame with function byte 0x02 loads both wheel speeds
// (big-endian, optionally negated). Each tick ages the link watchdog and steps
// the speed-request timer. The user must write configuration through the plain
// write port only while the stream is idle; the block does not enforce this.
module speed_frame_receiver_link_watchdog (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic [0:0]  s_axis_tuser,   // [0] cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [15:0] speed_a, [31:16] speed_b, [33:32] frame_status, [34] link_lost,
    // [35] send_request, [39:36] zero
    output logic [39:0] m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import sfrlw_pkg::*;

    logic [15:0] r_link_timeout;
    logic [15:0] r_request_period;
    logic        r_neg_a;
    logic        r_neg_b;

    logic [15:0] r_speed_a;
    logic [15:0] n_speed_a;
    logic [15:0] r_speed_b;
    logic [15:0] n_speed_b;
    logic        r_frame_since_tick;
    logic        n_frame_since_tick;
    logic [15:0] r_link_age;
    logic [15:0] n_link_age;
    logic [15:0] r_request_age;
    logic [15:0] n_request_age;
    logic [1:0]  n_status;
    logic        n_fire;

    logic        r_out_valid;
    logic [39:0] r_out_data;

    logic        w_accept;
    logic        w_tick;
    t_frame_evt  w_evt;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_tick        = s_axis_tuser[0];

    sfrlw_frame u_frame (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (w_accept && !w_tick),
        .i_byte  (s_axis_tdata),
        .i_neg_a (r_neg_a),
        .i_neg_b (r_neg_b),
        .o_evt   (w_evt)
    );

    always_comb begin
        n_speed_a          = r_speed_a;
        n_speed_b          = r_speed_b;
        n_frame_since_tick = r_frame_since_tick;
        n_link_age         = r_link_age;
        n_request_age      = r_request_age;
        n_status           = FS_NONE;
        n_fire             = 1'b0;
        if (w_tick) begin
            if (r_frame_since_tick) begin
                n_frame_since_tick = 1'b0;
                n_link_age         = '0;
            end else if (r_link_age < r_link_timeout) begin
                n_link_age = r_link_age + 16'd1;
            end
            if (r_request_age < r_request_period) begin
                n_request_age = r_request_age + 16'd1;
            end else begin
                n_request_age = '0;
                n_fire        = 1'b1;
            end
        end else begin
            n_status = w_evt.status;
            if (w_evt.status == FS_GOOD) begin
                n_speed_a          = w_evt.speed_a;
                n_speed_b          = w_evt.speed_b;
                n_frame_since_tick = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_timeout   <= LINK_TIMEOUT_RST;
            r_request_period <= REQUEST_PERIOD_RST;
            r_neg_a          <= 1'b0;
            r_neg_b          <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_LINK_TIMEOUT:   r_link_timeout   <= i_cfg_data;
                CFG_REQUEST_PERIOD: r_request_period <= i_cfg_data;
                CFG_NEGATE_A:       r_neg_a          <= i_cfg_data[0];
                CFG_NEGATE_B:       r_neg_b          <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_a          <= '0;
            r_speed_b          <= '0;
            r_frame_since_tick <= 1'b0;
            r_link_age         <= LINK_TIMEOUT_RST;
            r_request_age      <= '0;
        end else if (w_accept) begin
            r_speed_a          <= n_speed_a;
            r_speed_b          <= n_speed_b;
            r_frame_since_tick <= n_frame_since_tick;
            r_link_age         <= n_link_age;
            r_request_age      <= n_request_age;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data <= {4'd0, n_fire, (n_link_age >= r_link_timeout), n_status,
                           n_speed_b, n_speed_a};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

`ifndef SYNTHESIS
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> s_axis_tready)
        else $error("input stalled with the output register empty");

    a_request_not_on_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_data[35] && r_out_data[33:32] != FS_NONE))
        else $error("speed request and frame status in the same item");

    a_fed_tick_clears_age: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_tick && r_frame_since_tick) |=> (r_link_age == '0))
        else $error("link age not cleared after a fed tick");

    a_good_frame_feeds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_tick && w_evt.status == FS_GOOD) |=> r_frame_since_tick)
        else $error("good speed frame did not feed the watchdog");
`endif

endmodule

// ----- design/sfrlw_frame.sv -----
module sfrlw_frame (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_take,
    input  logic [7:0]          i_byte,
    input  logic                i_neg_a,
    input  logic                i_neg_b,
    output sfrlw_pkg::t_frame_evt o_evt
);
    import sfrlw_pkg::*;

    logic [2:0] r_count;
    logic [2:0] n_count;
    logic [7:0] r_sum;
    logic [7:0] n_sum;
    logic [7:0] r_frame [1:5];
    logic       w_store;
    logic [15:0] w_raw_a;
    logic [15:0] w_raw_b;

    assign w_raw_a = {r_frame[2], r_frame[3]};
    assign w_raw_b = {r_frame[4], r_frame[5]};

    always_comb begin
        n_count = r_count;
        n_sum   = r_sum;
        w_store = 1'b0;
        o_evt.status  = FS_NONE;
        o_evt.speed_a = i_neg_a ? 16'(16'd0 - w_raw_a) : w_raw_a;
        o_evt.speed_b = i_neg_b ? 16'(16'd0 - w_raw_b) : w_raw_b;
        if (r_count == SUM_POS) begin
            n_count = '0;
            n_sum   = '0;
            if (r_sum != i_byte) begin
                o_evt.status = FS_BAD_SUM;
            end else if (r_frame[1] != SPEED_FUNC) begin
                o_evt.status = FS_FOREIGN;
            end else begin
                o_evt.status = FS_GOOD;
            end
        end else if (r_count != '0 || i_byte == FRAME_HEAD) begin
            w_store = 1'b1;
            n_count = r_count + 3'd1;
            n_sum   = r_sum + i_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sum   <= '0;
        end else if (i_take) begin
            r_count <= n_count;
            r_sum   <= n_sum;
        end
    end

    // The head byte itself is never read back, so it is not kept.
    always_ff @(posedge i_clk) begin
        if (i_take && w_store && r_count != '0) begin
            r_frame[r_count] <= i_byte;
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= SUM_POS)
        else $error("frame byte count beyond the checksum position");

    a_sum_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_sum == '0))
        else $error("running sum not cleared between frames");
`endif

endmodule
